@@ rtl/assert_macros.svh @@
// Assertion macros for the segmenter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/qcs_pkg.sv @@
// Package of types, constants and arithmetic functions for the segmenter.
`default_nettype none
package qcs_pkg;

    localparam int MAX_PTS   = 32;
    localparam int IDX_W     = $clog2(MAX_PTS);
    localparam int CNT_W     = $clog2(MAX_PTS + 1);
    localparam int CW        = 32;
    localparam int PXW       = 16;
    localparam int SCW       = 12;
    localparam int SEGW      = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE = 1'd1;

    typedef enum logic [2:0] {
        KIND_END   = 3'd0,
        KIND_MOVE  = 3'd1,
        KIND_LINE  = 3'd2,
        KIND_QUAD  = 3'd3,
        KIND_CLOSE = 3'd4
    } t_kind;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic                 on_curve;
        logic                 contour_end;
        logic                 glyph_end;
        logic                 no_point;
    } t_in_word;

    typedef struct packed {
        logic [2:0]            seg_kind;
        logic signed [PXW-1:0] first_x;
        logic signed [PXW-1:0] first_y;
        logic signed [PXW-1:0] second_x;
        logic signed [PXW-1:0] second_y;
        logic [SEGW-1:0]       segment_total;
        logic                  overflow;
        logic                  last;
    } t_out_word;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 on;
    } t_pt;

    localparam int PT_W = $bits(t_pt);

    typedef enum logic {FS_START, FS_P} t_fsel;
    typedef enum logic [1:0] {SS_NONE, SS_ST, SS_Q, SS_MID} t_ssel;
    typedef enum logic [1:0] {RS_ZERO, RS_LAST, RS_IDX, RS_IDX1} t_rsel;

    typedef struct packed {
        logic  take;
        logic  rd_en;
        t_rsel rd_sel;
        logic  cap_a;
        logic  cap_p;
        logic  set_start;
        logic  emit;
        t_kind kind;
        t_fsel fsel;
        t_ssel ssel;
        logic  last;
        logic  inc1;
        logic  inc2;
        logic  clr_held;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic held_zero;
        logic idx_done;
        logic idx1_done;
        logic rd_on;
        logic gend_pending_n;
    } t_sts;

    // Product of a coordinate and its scale, saturated to 32 bits.
    function automatic logic signed [CW-1:0] scale_sat(input logic signed [CW-1:0] v,
                                                       input logic [SCW-1:0] s);
        logic signed [CW+SCW:0] p;
        logic signed [CW-1:0]   r;
        p = v * $signed({1'b0, s});
        if (&p[CW+SCW:CW-1] || !(|p[CW+SCW:CW-1])) begin
            r = p[CW-1:0];
        end else if (p[CW+SCW]) begin
            r = {1'b1, {(CW-1){1'b0}}};
        end else begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    // Half the sum, rounded to nearest with ties away from zero.
    function automatic logic signed [CW-1:0] half_sum(input logic signed [CW-1:0] a,
                                                      input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        logic signed [CW:0] t;
        s = {a[CW-1], a} + {b[CW-1], b};
        t = s + {{CW{1'b0}}, 1'b1};
        return s[CW] ? s[CW:1] : t[CW:1];
    endfunction

    // 16.16 value to a saturated integer pixel, optionally negated.
    function automatic logic signed [PXW-1:0] to_pixel(input logic signed [CW-1:0] v,
                                                       input logic negate);
        logic [CW:0]   mag;
        logic [CW:0]   sum;
        logic [PXW:0]  t;
        logic          neg;
        logic [PXW-1:0] r;
        mag = v[CW-1] ? ({1'b0, ~v} + {{CW{1'b0}}, 1'b1}) : {1'b0, v};
        sum = mag + (CW+1)'(32'h8000);
        t   = sum[CW:16];
        neg = v[CW-1] ^ negate;
        if (neg) begin
            r = PXW'(~t + {{PXW{1'b0}}, 1'b1});
        end else if (t > (PXW+1)'(17'h7fff)) begin
            r = {1'b0, {(PXW-1){1'b1}}};
        end else begin
            r = t[PXW-1:0];
        end
        return $signed(r);
    endfunction

endpackage
`default_nettype wire

@@ rtl/qcs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module qcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ rtl/qcs_controller.sv @@
// Sequencer that walks a buffered contour and issues datapath commands.
`default_nettype none
module qcs_controller (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire qcs_pkg::t_in_word i_in_word,
    output logic                 o_in_stall,
    input  wire qcs_pkg::t_sts   i_sts,
    output qcs_pkg::t_cmd        o_cmd
);
    import qcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RDE, S_START, S_LOOP, S_GETP,
        S_EMLINE, S_EMQST, S_GETQ, S_CLOSE, S_END
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;
    logic   w_has_pts;

    assign w_has_pts = !i_sts.held_zero || !i_in_word.no_point;

    always_comb begin
        n_state       = r_state;
        w_cmd         = '0;
        w_cmd.rd_sel  = RS_ZERO;
        w_cmd.kind    = KIND_END;
        w_cmd.fsel    = FS_P;
        w_cmd.ssel    = SS_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.take = 1'b1;
                    if (i_in_word.contour_end || i_in_word.glyph_end) begin
                        if (w_has_pts) begin
                            n_state = S_RD0;
                        end else if (i_in_word.glyph_end) begin
                            n_state = S_END;
                        end
                    end
                end
            end
            S_RD0: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = RS_ZERO;
                n_state      = S_RDE;
            end
            S_RDE: begin
                w_cmd.cap_a  = 1'b1;
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = RS_LAST;
                n_state      = S_START;
            end
            S_START: begin
                if (i_sts.out_free) begin
                    w_cmd.emit      = 1'b1;
                    w_cmd.kind      = KIND_MOVE;
                    w_cmd.fsel      = FS_START;
                    w_cmd.set_start = 1'b1;
                    n_state         = S_LOOP;
                end
            end
            S_LOOP: begin
                if (i_sts.idx_done) begin
                    n_state = S_CLOSE;
                end else begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RS_IDX;
                    n_state      = S_GETP;
                end
            end
            S_GETP: begin
                w_cmd.cap_p = 1'b1;
                if (i_sts.rd_on) begin
                    n_state = S_EMLINE;
                end else if (i_sts.idx1_done) begin
                    n_state = S_EMQST;
                end else begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RS_IDX1;
                    n_state      = S_GETQ;
                end
            end
            S_EMLINE: begin
                if (i_sts.out_free) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.kind = KIND_LINE;
                    w_cmd.inc1 = 1'b1;
                    n_state    = S_LOOP;
                end
            end
            S_EMQST: begin
                if (i_sts.out_free) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.kind = KIND_QUAD;
                    w_cmd.ssel = SS_ST;
                    w_cmd.inc1 = 1'b1;
                    n_state    = S_LOOP;
                end
            end
            S_GETQ: begin
                if (i_sts.out_free) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.kind = KIND_QUAD;
                    w_cmd.ssel = i_sts.rd_on ? SS_Q : SS_MID;
                    w_cmd.inc2 = i_sts.rd_on;
                    w_cmd.inc1 = !i_sts.rd_on;
                    n_state    = S_LOOP;
                end
            end
            S_CLOSE: begin
                if (i_sts.out_free) begin
                    w_cmd.emit     = 1'b1;
                    w_cmd.kind     = KIND_CLOSE;
                    w_cmd.clr_held = 1'b1;
                    w_cmd.last     = !i_sts.gend_pending_n ? 1'b0 : 1'b1;
                    n_state        = i_sts.gend_pending_n ? S_IDLE : S_END;
                end
            end
            S_END: begin
                if (i_sts.out_free) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.kind = KIND_END;
                    w_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = w_cmd;
endmodule
`default_nettype wire

@@ rtl/qcs_datapath.sv @@
// Datapath: scaling, contour buffer, start point, midpoints and output register.
`default_nettype none
`include "assert_macros.svh"
module qcs_datapath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire qcs_pkg::t_in_word     i_in_word,
    input  wire logic                  i_cfg_we,
    input  wire logic [qcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [qcs_pkg::SCW-1:0] i_cfg_data,
    input  wire qcs_pkg::t_cmd         i_cmd,
    output qcs_pkg::t_sts              o_sts,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output qcs_pkg::t_out_word         o_out_word
);
    import qcs_pkg::*;

    logic [SCW-1:0]  r_x_scale;
    logic [SCW-1:0]  r_y_scale;
    logic [CNT_W-1:0] r_held;
    logic [CNT_W-1:0] r_idx;
    logic [SEGW-1:0] r_segs;
    logic            r_drop;
    logic            r_gend;
    t_pt             r_a;
    t_pt             r_p;
    logic signed [CW-1:0] r_st_x;
    logic signed [CW-1:0] r_st_y;
    logic            r_out_valid;
    t_out_word       r_out_word;

    logic            w_full;
    logic            w_we;
    t_pt             w_wdata;
    t_pt             w_rd;
    logic [PT_W-1:0] w_rd_bits;
    logic [CNT_W-1:0] w_last;
    logic [CNT_W-1:0] w_idx1;
    logic [IDX_W-1:0] w_raddr;
    logic signed [CW-1:0] w_start_x;
    logic signed [CW-1:0] w_start_y;
    logic signed [CW-1:0] w_fx;
    logic signed [CW-1:0] w_fy;
    logic signed [CW-1:0] w_sx;
    logic signed [CW-1:0] w_sy;
    logic            w_out_free;
    logic            w_has_first;
    t_out_word       w_word;

    assign w_full  = (r_held == CNT_W'(MAX_PTS));
    assign w_we    = i_cmd.take && !i_in_word.no_point && !w_full;
    assign w_wdata = '{x:  scale_sat(i_in_word.point_x, r_x_scale),
                       y:  scale_sat(i_in_word.point_y, r_y_scale),
                       on: i_in_word.on_curve};
    assign w_last  = r_held - CNT_W'(1);
    assign w_idx1  = r_idx + CNT_W'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            RS_ZERO: w_raddr = '0;
            RS_LAST: w_raddr = w_last[IDX_W-1:0];
            RS_IDX:  w_raddr = r_idx[IDX_W-1:0];
            default: w_raddr = w_idx1[IDX_W-1:0];
        endcase
    end

    qcs_ram #(.WIDTH(PT_W), .DEPTH(MAX_PTS)) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_held[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_bits)
    );
    assign w_rd = w_rd_bits;

    // Start point: first point if on curve, else last if on curve, else their midpoint.
    always_comb begin
        if (r_a.on) begin
            w_start_x = r_a.x;
            w_start_y = r_a.y;
        end else if (w_rd.on) begin
            w_start_x = w_rd.x;
            w_start_y = w_rd.y;
        end else begin
            w_start_x = half_sum(r_a.x, w_rd.x);
            w_start_y = half_sum(r_a.y, w_rd.y);
        end
    end

    always_comb begin
        w_fx = (i_cmd.fsel == FS_START) ? w_start_x : r_p.x;
        w_fy = (i_cmd.fsel == FS_START) ? w_start_y : r_p.y;
        case (i_cmd.ssel)
            SS_ST: begin
                w_sx = r_st_x;
                w_sy = r_st_y;
            end
            SS_Q: begin
                w_sx = w_rd.x;
                w_sy = w_rd.y;
            end
            SS_MID: begin
                w_sx = half_sum(r_p.x, w_rd.x);
                w_sy = half_sum(r_p.y, w_rd.y);
            end
            default: begin
                w_sx = '0;
                w_sy = '0;
            end
        endcase
    end

    assign w_has_first = (i_cmd.kind != KIND_CLOSE) && (i_cmd.kind != KIND_END);

    always_comb begin
        w_word               = '0;
        w_word.seg_kind      = i_cmd.kind;
        w_word.first_x       = w_has_first ? to_pixel(w_fx, 1'b0) : '0;
        w_word.first_y       = w_has_first ? to_pixel(w_fy, 1'b1) : '0;
        w_word.second_x      = (i_cmd.ssel != SS_NONE) ? to_pixel(w_sx, 1'b0) : '0;
        w_word.second_y      = (i_cmd.ssel != SS_NONE) ? to_pixel(w_sy, 1'b1) : '0;
        w_word.segment_total = (i_cmd.kind == KIND_END) ? r_segs : '0;
        w_word.overflow      = (i_cmd.kind == KIND_END) ? r_drop : 1'b0;
        w_word.last          = i_cmd.last;
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_scale   <= SCW'(1);
            r_y_scale   <= SCW'(1);
            r_held      <= '0;
            r_idx       <= '0;
            r_segs      <= '0;
            r_drop      <= 1'b0;
            r_gend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_X_SCALE) begin
                    r_x_scale <= i_cfg_data;
                end
                if (i_cfg_index == CFG_Y_SCALE) begin
                    r_y_scale <= i_cfg_data;
                end
            end
            if (i_cmd.take) begin
                r_gend <= i_in_word.glyph_end;
                if (w_we) begin
                    r_held <= r_held + CNT_W'(1);
                end else if (!i_in_word.no_point) begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.clr_held) begin
                r_held <= '0;
            end
            if (i_cmd.set_start) begin
                r_idx <= r_a.on ? CNT_W'(1) : '0;
            end else if (i_cmd.inc2) begin
                r_idx <= r_idx + CNT_W'(2);
            end else if (i_cmd.inc1) begin
                r_idx <= w_idx1;
            end else if (i_cmd.clr_held) begin
                r_idx <= '0;
            end
            if (i_cmd.emit) begin
                if (i_cmd.kind == KIND_END) begin
                    r_segs <= '0;
                    r_drop <= 1'b0;
                end else if (r_segs != {SEGW{1'b1}}) begin
                    r_segs <= r_segs + SEGW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_a) begin
            r_a <= w_rd;
        end
        if (i_cmd.cap_p) begin
            r_p <= w_rd;
        end
        if (i_cmd.set_start) begin
            r_st_x <= w_start_x;
            r_st_y <= w_start_y;
        end
        if (i_cmd.emit) begin
            r_out_word <= w_word;
        end
    end

    assign o_sts.out_free       = w_out_free;
    assign o_sts.held_zero      = (r_held == '0);
    assign o_sts.idx_done       = (r_idx >= r_held);
    assign o_sts.idx1_done      = ({1'b0, r_idx} + (CNT_W+1)'(1)) >= {1'b0, r_held};
    assign o_sts.rd_on          = w_rd.on;
    assign o_sts.gend_pending_n = !r_gend;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ASSERT_CLK(a_idx_bound, r_idx <= r_held, "walk index ran past the held point count")
    `ASSERT_CLK(a_emit_free, i_cmd.emit |-> w_out_free, "word loaded into a busy output register")
    `ASSERT_CLK(a_end_clears, (i_cmd.emit && i_cmd.kind == KIND_END) |=> (r_segs == '0 && !r_drop), "glyph counters not cleared after end word")
    `ASSERT_ALWAYS(a_rst_out, !i_rst_n |=> !r_out_valid, "output valid survived reset")
endmodule
`default_nettype wire

@@ rtl/quadratic_contour_segmenter.sv @@
// After a contour-ending word, S_RD0 and S_RDE read its first and last points and S_START
// loads the move word once the output register is free. Each line, lone control point and
// control point taken with its on-curve end point passes fetch, capture and emit states, set
// by the contour buffer's single read port; a contour adds start and close states, a glyph
// end an end state. Other input words are taken every cycle; input stalls outside S_IDLE.
// Reset (synchronous, active low) clears the counters and flags and sets the scales to one.
`default_nettype none
module quadratic_contour_segmenter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire qcs_pkg::t_in_word            i_in_word,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output qcs_pkg::t_out_word                o_out_word,
    input  wire logic                         i_cfg_we,
    input  wire logic [qcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [qcs_pkg::SCW-1:0]      i_cfg_data
);
    import qcs_pkg::*;

    // The controller walks the buffered contour; the datapath holds the buffer,
    // the scale registers, the glyph counters and the output register.
    // The point buffer is not cleared; only entries written in the current contour are read.
    t_cmd w_cmd;
    t_sts w_sts;

    qcs_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    qcs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );
endmodule
`default_nettype wire

@@ tb/sv/quadratic_contour_segmenter_checker.sv @@
// Checker for the segmenter: watches both channels, predicts each result word and compares.
`default_nettype none
module quadratic_contour_segmenter_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_stall,
    input  wire qcs_pkg::t_in_word             i_in_word,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire qcs_pkg::t_out_word            i_out_word,
    input  wire logic                          i_cfg_we,
    input  wire logic [qcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [qcs_pkg::SCW-1:0]       i_cfg_data,
    output int                                 o_failures,
    output int                                 o_pending,
    output int                                 o_words_in,
    output int                                 o_words_out
);
    import qcs_pkg::*;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    t_out_word segments_due[$];

    logic [SCW-1:0] x_mult;
    logic [SCW-1:0] y_mult;
    longint         pt_x [MAX_PTS];
    longint         pt_y [MAX_PTS];
    bit             pt_on[MAX_PTS];
    int             pts_held;
    int             seg_count;
    bit             pts_dropped;
    int             words_made;

    function automatic longint clamp32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic longint mid_round(longint a, longint b);
        longint s;
        s = a + b;
        if (s >= 0) return (s + 1) / 2;
        return -((-s + 1) / 2);
    endfunction

    function automatic logic signed [PXW-1:0] pixel_of(longint v, bit negate);
        longint r;
        if (v < 0) r = -((-v + 32768) >> 16);
        else r = (v + 32768) >> 16;
        if (negate) r = -r;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[PXW-1:0];
    endfunction

    task automatic push_segment(t_kind kind, longint ax, longint ay, longint bx, longint by,
                                bit has_b);
        t_out_word w;
        w = '0;
        w.seg_kind = kind;
        if (kind != KIND_CLOSE) begin
            w.first_x = pixel_of(ax, 0);
            w.first_y = pixel_of(ay, 1);
        end
        if (has_b) begin
            w.second_x = pixel_of(bx, 0);
            w.second_y = pixel_of(by, 1);
        end
        segments_due.push_back(w);
        words_made++;
        if (seg_count < 65535) seg_count++;
    endtask

    // Walks the buffered contour: start point, then lines and quadratics, then a close.
    task automatic flush_contour();
        int     i;
        int     left;
        int     e;
        longint sx;
        longint sy;
        longint px;
        longint py;
        i = 0;
        left = pts_held;
        if (pts_held == 0) return;
        e = pts_held - 1;
        if (pt_on[0]) begin
            sx = pt_x[0];
            sy = pt_y[0];
            i = 1;
            left = pts_held - 1;
        end else if (pt_on[e]) begin
            sx = pt_x[e];
            sy = pt_y[e];
        end else begin
            sx = mid_round(pt_x[0], pt_x[e]);
            sy = mid_round(pt_y[0], pt_y[e]);
        end
        push_segment(KIND_MOVE, sx, sy, 0, 0, 0);
        while (left > 0 && i < pts_held) begin
            px = pt_x[i];
            py = pt_y[i];
            i++;
            left--;
            if (pt_on[i-1]) begin
                push_segment(KIND_LINE, px, py, 0, 0, 0);
            end else if (left == 0 || i >= pts_held) begin
                push_segment(KIND_QUAD, px, py, sx, sy, 1);
            end else if (pt_on[i]) begin
                push_segment(KIND_QUAD, px, py, pt_x[i], pt_y[i], 1);
                i++;
                left--;
            end else begin
                push_segment(KIND_QUAD, px, py, mid_round(px, pt_x[i]),
                             mid_round(py, pt_y[i]), 1);
            end
        end
        push_segment(KIND_CLOSE, 0, 0, 0, 0, 0);
        pts_held = 0;
    endtask

    task automatic segment_word(t_in_word w);
        t_out_word fin;
        words_made = 0;
        if (!w.no_point) begin
            if (pts_held < MAX_PTS) begin
                pt_x[pts_held]  = clamp32(longint'(w.point_x) * longint'({1'b0, x_mult}));
                pt_y[pts_held]  = clamp32(longint'(w.point_y) * longint'({1'b0, y_mult}));
                pt_on[pts_held] = w.on_curve;
                pts_held++;
            end else begin
                pts_dropped = 1;
            end
        end
        if (w.contour_end || w.glyph_end) flush_contour();
        if (w.glyph_end) begin
            fin = '0;
            fin.seg_kind = KIND_END;
            fin.segment_total = seg_count[SEGW-1:0];
            fin.overflow = pts_dropped;
            segments_due.push_back(fin);
            words_made++;
            seg_count = 0;
            pts_dropped = 0;
        end
        // The final word caused by this input carries the last flag.
        if (words_made > 0) segments_due[$].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            x_mult = 1;
            y_mult = 1;
            pts_held = 0;
            seg_count = 0;
            pts_dropped = 0;
            segments_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_words_out <= o_words_out + 1;
                if (segments_due.size() == 0) begin
                    $error("unexpected result word kind %0d", i_out_word.seg_kind);
                    o_failures <= o_failures + 1;
                end else begin
                    exp_w = segments_due.pop_front();
                    if (exp_w != i_out_word) begin
                        o_failures <= o_failures + 1;
                        if (exp_w.seg_kind != i_out_word.seg_kind)
                            $error("seg_kind: expected %0d, got %0d",
                                   exp_w.seg_kind, i_out_word.seg_kind);
                        if (exp_w.first_x != i_out_word.first_x)
                            $error("first_x: expected %0d, got %0d",
                                   exp_w.first_x, i_out_word.first_x);
                        if (exp_w.first_y != i_out_word.first_y)
                            $error("first_y: expected %0d, got %0d",
                                   exp_w.first_y, i_out_word.first_y);
                        if (exp_w.second_x != i_out_word.second_x)
                            $error("second_x: expected %0d, got %0d",
                                   exp_w.second_x, i_out_word.second_x);
                        if (exp_w.second_y != i_out_word.second_y)
                            $error("second_y: expected %0d, got %0d",
                                   exp_w.second_y, i_out_word.second_y);
                        if (exp_w.segment_total != i_out_word.segment_total)
                            $error("segment_total: expected %0d, got %0d",
                                   exp_w.segment_total, i_out_word.segment_total);
                        if (exp_w.overflow != i_out_word.overflow)
                            $error("overflow: expected %0d, got %0d",
                                   exp_w.overflow, i_out_word.overflow);
                        if (exp_w.last != i_out_word.last)
                            $error("last: expected %0d, got %0d",
                                   exp_w.last, i_out_word.last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                o_words_in <= o_words_in + 1;
                segment_word(i_in_word);
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_X_SCALE) x_mult = i_cfg_data;
                else if (i_cfg_index == CFG_Y_SCALE) y_mult = i_cfg_data;
            end
        end
        o_pending <= segments_due.size();
    end

endmodule
`default_nettype wire

@@ tb/sv/quadratic_contour_segmenter_test.sv @@
// Top of the segmenter testbench: clock, reset, stimulus, flow control and the verdict.
`default_nettype none
module quadratic_contour_segmenter_test;
    import qcs_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_word             in_word = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_word            out_word;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_X_SCALE;
    logic [SCW-1:0]       cfg_data = '0;

    int failures;
    int pending;
    int words_in;
    int words_out;

    // Flow-control knobs, in percent, changed per phase by the stimulus process.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    // The stimulus bumps this to ask the stall process for one long hold-off.
    int hold_requests = 0;
    int holds_seen = 0;
    int hold_left = 0;
    int words_sent = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    quadratic_contour_segmenter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    quadratic_contour_segmenter_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_pending   (pending),
        .o_words_in  (words_in),
        .o_words_out (words_out)
    );

    // Receiver side: random stalls at the phase rate, or a long counted hold-off on request.
    always @(posedge i_clk) begin
        if (hold_requests != holds_seen) begin
            holds_seen <= hold_requests;
            hold_left <= 400;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Offers one word and returns at the edge that accepts it. Valid is left high so that
    // back-to-back words never lower and raise it in the same step.
    task automatic offer_word(t_in_word w);
        logic taken;
        if ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !in_stall;
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    // Sender pause: nothing is offered until every predicted word has come back, then the
    // block is left to settle before any register write.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_scales(logic [SCW-1:0] xs, logic [SCW-1:0] ys);
        cfg_we <= 1'b1;
        cfg_index <= CFG_X_SCALE;
        cfg_data <= xs;
        @(posedge i_clk);
        cfg_index <= CFG_Y_SCALE;
        cfg_data <= ys;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Mixes fully random coordinates with small ones, rounding ties and the 32-bit extremes.
    function automatic logic signed [CW-1:0] pick_coord();
        logic signed [CW-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $signed($urandom_range(600 << 16)) - (300 << 16);
            2: begin
                case ($urandom_range(4))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = 32'sh0000_8000;
                    3: v = 32'shffff_8000;
                    default: v = '0;
                endcase
            end
            default: v = ($signed($urandom_range(200)) - 100) * 65536 + 32'sh8000;
        endcase
        return v;
    endfunction

    function automatic t_in_word make_point(bit on, bit cend, bit gend);
        t_in_word w;
        w.point_x = pick_coord();
        w.point_y = pick_coord();
        w.on_curve = on;
        w.contour_end = cend;
        w.glyph_end = gend;
        w.no_point = 1'b0;
        return w;
    endfunction

    function automatic t_in_word make_marker(bit cend, bit gend);
        t_in_word w;
        w = make_point(1'($urandom_range(1)), cend, gend);
        w.no_point = 1'b1;
        return w;
    endfunction

    // One glyph of well-formed contours with random content, some noise and some endings
    // that leave the last contour open. A big glyph can overrun the contour buffer.
    task automatic send_glyph(bit big);
        int n_contours;
        int len;
        int ending;
        n_contours = $urandom_range(3, 1);
        for (int c = 0; c < n_contours; c++) begin
            len = big ? $urandom_range(38, 30) : $urandom_range(7, 1);
            ending = $urandom_range(9);
            for (int p = 0; p < len; p++) begin
                if ($urandom_range(19) == 0) offer_word(make_marker(0, 0));
                if (p == len - 1 && ending > 1)
                    offer_word(make_point(1'($urandom_range(1)), 1, 0));
                else
                    offer_word(make_point(1'($urandom_range(1)), 0, 0));
            end
            // Its last point or a marker closes it, or it stays open for the glyph end.
            if (ending == 1) offer_word(make_marker(1, 0));
            else if (ending == 0 && c != n_contours - 1) offer_word(make_marker(1, 0));
        end
        if ($urandom_range(1)) offer_word(make_marker(1'($urandom_range(1)), 1));
        else offer_word(make_point(1'($urandom_range(1)), 1'($urandom_range(1)), 1));
    endtask

    task automatic directed_words();
        t_in_word w;
        // A lone on-curve point, closed and ended in one word.
        offer_word(make_point(1, 1, 1));
        // Two control points: the start is their implied midpoint.
        offer_word(make_point(0, 0, 0));
        offer_word(make_point(0, 1, 0));
        // Control point first, on-curve last: the start is the last point.
        offer_word(make_point(0, 0, 0));
        offer_word(make_point(0, 0, 0));
        offer_word(make_point(1, 1, 0));
        // Extreme coordinates in both directions.
        w = make_point(1, 0, 0);
        w.point_x = 32'sh7fff_ffff;
        w.point_y = 32'sh8000_0000;
        offer_word(w);
        w.point_x = 32'sh8000_0000;
        w.point_y = 32'sh7fff_ffff;
        w.on_curve = 1'b0;
        offer_word(w);
        // Contour closed by a marker word.
        offer_word(make_marker(1, 0));
        // Contour end with nothing buffered, and a word that is merely ignored.
        offer_word(make_marker(1, 0));
        offer_word(make_marker(0, 0));
        // Open contour closed by the glyph end on a point word.
        offer_word(make_point(1, 0, 0));
        offer_word(make_point(0, 0, 1));
        // Glyph end with no contour at all.
        offer_word(make_marker(0, 1));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_words();
        drain_results();

        // Each phase pairs a scale setting with a flow-control mix.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_scales(1, 1);
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    write_scales(4095, 4095);
                    sender_idle_pct = 45;
                    receiver_stall_pct = 0;
                end
                2: begin
                    write_scales(0, SCW'($urandom_range(4095)));
                    sender_idle_pct = 0;
                    receiver_stall_pct = 45;
                end
                3: begin
                    write_scales(SCW'($urandom_range(4095)), 0);
                    sender_idle_pct = 12;
                    receiver_stall_pct = 12;
                end
                default: begin
                    write_scales(SCW'($urandom_range(4095, 1)), SCW'($urandom_range(4095, 1)));
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            if (phase == 1) begin
                // Long receiver hold-off while the sender keeps offering a full contour.
                hold_requests++;
                send_glyph(1);
            end
            while (words_sent < 20 + 90 * (phase + 1))
                send_glyph($urandom_range(14) == 0);
            drain_results();
        end

        $display("Sent %0d input words and checked %0d result words across five scale settings,",
                 words_in, words_out);
        $display("with idle, stall, long hold-off and buffer overrun cases on both channels.");
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/qcs_pkg.sv
rtl/qcs_ram.sv
rtl/qcs_controller.sv
rtl/qcs_datapath.sv
rtl/quadratic_contour_segmenter.sv
tb/sv/quadratic_contour_segmenter_checker.sv
tb/sv/quadratic_contour_segmenter_test.sv
